FILE: rtl/core/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the strongly connected components unit.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;

  localparam int VCOUNT_W = 7;                 // width of the vertex_count register
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam int DISC_W   = 7;                 // discovery and low-link numbers
  localparam int FIELD_VW = 6;                 // vertex fields of the words
  localparam int COMP_W   = 6;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [FIELD_VW-1:0] source_vertex;
    logic [FIELD_VW-1:0] target_vertex;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_VW-1:0] vertex;
    logic [COMP_W-1:0]   component;
    logic                component_end;
    logic                run_end;
    logic                edges_dropped;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WR,
    S_ROOT,
    S_ENTER,
    S_STEP,
    S_EDGE,
    S_CMP,
    S_POPCHK,
    S_POP,
    S_RET,
    S_PAR,
    S_FIN
  } state_t;

endpackage

FILE: rtl/core/scc_ram.sv
// ----------------------------------------------------------------------------
// scc_ram
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/strongly_connected_components_unit.sv
// ----------------------------------------------------------------------------
// strongly_connected_components_unit
// Directed edge store plus an iterative Tarjan search that emits components.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_stall   in_word_t (add edge or run)
//   out_     output     out_valid/out_stall out_word_t (one popped vertex)
//   cfg_     input      cfg_wr_en           vertex_count, 7 bits
//
// An add-edge word first reads the adjacency head of the source vertex and
// then links the new edge in. The pace of a run per visited vertex and per
// edge examined is set by the registered reads of the edge, frame and
// discovery memories. Reset is synchronous and active low; it empties the
// edge store and leaves vertex_count at 64. A stalled output holds one
// result in the output register and one more in a pending register; the
// search waits on a stall only when both are full. The last result of a run
// sits in the pending register until the search ends, so it can be marked
// as the run end.
// ----------------------------------------------------------------------------
module strongly_connected_components_unit #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  scc_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output scc_pkg::out_word_t           out_word,
  input  logic                         cfg_wr_en,
  input  logic [scc_pkg::VCOUNT_W-1:0] cfg_wr_data
);

  localparam int VW  = $clog2(MAX_VERTICES);           // vertex index
  localparam int CW  = $clog2(MAX_VERTICES + 1);       // stack and frame depth
  localparam int EW  = $clog2(MAX_EDGES + 1);          // edge pointer, holds NO_EDGE
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NW  = scc_pkg::VCOUNT_W;
  localparam int DW  = scc_pkg::DISC_W;
  localparam int FW  = VW + EW + 2 * DW;               // one saved frame
  localparam logic [EW-1:0] NO_EDGE  = EW'(MAX_EDGES);
  localparam logic [NW-1:0] MAXV_N   = NW'(MAX_VERTICES);

  // Registers.
  scc_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]   vcount_r;
  logic [EW-1:0]   edge_count_r, edge_count_nxt;
  logic            overflow_r, overflow_nxt;
  logic [MAX_VERTICES-1:0] head_v_r, head_v_nxt;
  logic [MAX_VERTICES-1:0] disc_v_r, disc_v_nxt;
  logic [MAX_VERTICES-1:0] onstk_r, onstk_nxt;
  logic [VW-1:0]   add_s_r, add_s_nxt;
  logic [VW-1:0]   add_t_r, add_t_nxt;
  logic [VW-1:0]   enter_v_r, enter_v_nxt;
  logic [NW-1:0]   root_r, root_nxt;
  logic [DW-1:0]   visit_r, visit_nxt;
  logic [CW-1:0]   sp_r, sp_nxt;
  logic [CW-1:0]   depth_r, depth_nxt;
  logic [scc_pkg::COMP_W-1:0] comp_r, comp_nxt;
  logic            dropped_r, dropped_nxt;
  logic [VW-1:0]   top_u_r, top_u_nxt;
  logic [EW-1:0]   top_cur_r, top_cur_nxt;
  logic [DW-1:0]   top_low_r, top_low_nxt;
  logic [DW-1:0]   top_disc_r, top_disc_nxt;
  logic            pend_v_r, pend_v_nxt;
  scc_pkg::out_word_t pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  scc_pkg::out_word_t out_word_r, out_word_nxt;

  // Memory ports.
  logic            head_we, head_re;
  logic [VW-1:0]   head_wa, head_ra;
  logic [EW-1:0]   head_wd, head_rd;
  logic            edge_we, edge_re;
  logic [EAW-1:0]  edge_wa, edge_ra;
  logic [VW+EW-1:0] edge_wd, edge_rd;
  logic            disc_we, disc_re;
  logic [VW-1:0]   disc_wa, disc_ra;
  logic [DW-1:0]   disc_wd, disc_rd;
  logic            stk_we, stk_re;
  logic [VW-1:0]   stk_wa, stk_ra;
  logic [VW-1:0]   stk_wd, stk_rd;
  logic            frm_we, frm_re;
  logic [VW-1:0]   frm_wa, frm_ra;
  logic [FW-1:0]   frm_wd, frm_rd;

  // Decoded conditions.
  logic [NW-1:0]   n_eff;
  logic            in_acc, add_bad, can_emit, out_free;
  logic [VW-1:0]   e_tgt;
  logic [EW-1:0]   e_next;
  logic [EW-1:0]   head_eff;
  logic            done_pop;
  logic [VW-1:0]   fr_u;
  logic [EW-1:0]   fr_cur;
  logic [DW-1:0]   fr_low, fr_disc;

  assign n_eff    = (vcount_r > MAXV_N) ? MAXV_N : vcount_r;
  assign in_stall = (state_r != scc_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign add_bad  = ({1'b0, in_word.source_vertex} >= n_eff)
                 || ({1'b0, in_word.target_vertex} >= n_eff)
                 || (edge_count_r == NO_EDGE);
  assign out_free = !out_valid_r || !out_stall;
  assign can_emit = !pend_v_r || out_free;
  assign {e_tgt, e_next} = edge_rd;
  assign head_eff = head_v_r[enter_v_r] ? head_rd : NO_EDGE;
  assign done_pop = (stk_rd == top_u_r);
  assign {fr_u, fr_cur, fr_low, fr_disc} = frm_rd;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_word.operation == scc_pkg::OP_RUN) begin
            state_nxt = scc_pkg::S_ROOT;
          end else if (!add_bad) begin
            state_nxt = scc_pkg::S_ADD_WR;
          end
        end
      end
      scc_pkg::S_ADD_WR: state_nxt = scc_pkg::S_IDLE;
      scc_pkg::S_ROOT: begin
        if (root_r >= n_eff) begin
          state_nxt = scc_pkg::S_FIN;
        end else if (!disc_v_r[root_r[VW-1:0]]) begin
          state_nxt = scc_pkg::S_ENTER;
        end
      end
      scc_pkg::S_ENTER: state_nxt = scc_pkg::S_STEP;
      scc_pkg::S_STEP: begin
        state_nxt = (top_cur_r != NO_EDGE) ? scc_pkg::S_EDGE : scc_pkg::S_POPCHK;
      end
      scc_pkg::S_EDGE: begin
        if ({{(NW-VW){1'b0}}, e_tgt} >= n_eff) begin
          state_nxt = scc_pkg::S_STEP;
        end else if (!disc_v_r[e_tgt]) begin
          state_nxt = scc_pkg::S_ENTER;
        end else if (onstk_r[e_tgt]) begin
          state_nxt = scc_pkg::S_CMP;
        end else begin
          state_nxt = scc_pkg::S_STEP;
        end
      end
      scc_pkg::S_CMP: state_nxt = scc_pkg::S_STEP;
      scc_pkg::S_POPCHK: begin
        state_nxt = (top_low_r == top_disc_r) ? scc_pkg::S_POP : scc_pkg::S_RET;
      end
      scc_pkg::S_POP: begin
        if (can_emit && done_pop) begin
          state_nxt = scc_pkg::S_RET;
        end
      end
      scc_pkg::S_RET: begin
        state_nxt = (depth_r > CW'(1)) ? scc_pkg::S_PAR : scc_pkg::S_ROOT;
      end
      scc_pkg::S_PAR: state_nxt = scc_pkg::S_STEP;
      scc_pkg::S_FIN: begin
        if (!pend_v_r || out_free) begin
          state_nxt = scc_pkg::S_IDLE;
        end
      end
      default: state_nxt = scc_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    edge_count_nxt = edge_count_r;
    overflow_nxt   = overflow_r;
    head_v_nxt     = head_v_r;
    disc_v_nxt     = disc_v_r;
    onstk_nxt      = onstk_r;
    add_s_nxt      = add_s_r;
    add_t_nxt      = add_t_r;
    enter_v_nxt    = enter_v_r;
    root_nxt       = root_r;
    visit_nxt      = visit_r;
    sp_nxt         = sp_r;
    depth_nxt      = depth_r;
    comp_nxt       = comp_r;
    dropped_nxt    = dropped_r;
    top_u_nxt      = top_u_r;
    top_cur_nxt    = top_cur_r;
    top_low_nxt    = top_low_r;
    top_disc_nxt   = top_disc_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;

    head_we = 1'b0; head_wa = add_s_r; head_wd = edge_count_r;
    head_re = 1'b0; head_ra = in_word.source_vertex[VW-1:0];
    edge_we = 1'b0; edge_wa = edge_count_r[EAW-1:0];
    edge_wd = {add_t_r, head_v_r[add_s_r] ? head_rd : NO_EDGE};
    edge_re = 1'b0; edge_ra = top_cur_r[EAW-1:0];
    disc_we = 1'b0; disc_wa = enter_v_r; disc_wd = visit_r + DW'(1);
    disc_re = 1'b0; disc_ra = e_tgt;
    stk_we  = 1'b0; stk_wa  = sp_r[VW-1:0]; stk_wd = enter_v_r;
    stk_re  = 1'b0; stk_ra  = VW'(sp_r - CW'(1));
    frm_we  = 1'b0; frm_wa  = VW'(depth_r - CW'(1));
    frm_wd  = {top_u_r, top_cur_r, top_low_r, top_disc_r};
    frm_re  = 1'b0; frm_ra  = VW'(depth_r - CW'(2));

    case (state_r)
      scc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_word.operation == scc_pkg::OP_RUN) begin
            dropped_nxt = overflow_r;
            disc_v_nxt  = '0;
            onstk_nxt   = '0;
            visit_nxt   = '0;
            sp_nxt      = '0;
            depth_nxt   = '0;
            comp_nxt    = '0;
            root_nxt    = '0;
          end else if (add_bad) begin
            overflow_nxt = 1'b1;
          end else begin
            head_re   = 1'b1;
            add_s_nxt = in_word.source_vertex[VW-1:0];
            add_t_nxt = in_word.target_vertex[VW-1:0];
          end
        end
      end
      scc_pkg::S_ADD_WR: begin
        edge_we          = 1'b1;
        head_we          = 1'b1;
        head_v_nxt[add_s_r] = 1'b1;
        edge_count_nxt   = edge_count_r + EW'(1);
      end
      scc_pkg::S_ROOT: begin
        if (root_r < n_eff) begin
          if (disc_v_r[root_r[VW-1:0]]) begin
            root_nxt = root_r + NW'(1);
          end else begin
            enter_v_nxt = root_r[VW-1:0];
            head_re     = 1'b1;
            head_ra     = root_r[VW-1:0];
          end
        end
      end
      scc_pkg::S_ENTER: begin
        visit_nxt             = visit_r + DW'(1);
        disc_we               = 1'b1;
        disc_v_nxt[enter_v_r] = 1'b1;
        onstk_nxt[enter_v_r]  = 1'b1;
        stk_we                = 1'b1;
        sp_nxt                = sp_r + CW'(1);
        frm_we                = (depth_r != '0);
        depth_nxt             = depth_r + CW'(1);
        top_u_nxt             = enter_v_r;
        top_cur_nxt           = head_eff;
        top_low_nxt           = visit_r + DW'(1);
        top_disc_nxt          = visit_r + DW'(1);
      end
      scc_pkg::S_STEP: begin
        edge_re = (top_cur_r != NO_EDGE);
      end
      scc_pkg::S_EDGE: begin
        top_cur_nxt = e_next;
        if ({{(NW-VW){1'b0}}, e_tgt} < n_eff) begin
          if (!disc_v_r[e_tgt]) begin
            enter_v_nxt = e_tgt;
            head_re     = 1'b1;
            head_ra     = e_tgt;
          end else if (onstk_r[e_tgt]) begin
            disc_re = 1'b1;
          end
        end
      end
      scc_pkg::S_CMP: begin
        if (disc_rd < top_low_r) begin
          top_low_nxt = disc_rd;
        end
      end
      scc_pkg::S_POPCHK: begin
        stk_re = (top_low_r == top_disc_r);
      end
      scc_pkg::S_POP: begin
        if (can_emit) begin
          sp_nxt          = sp_r - CW'(1);
          onstk_nxt[stk_rd] = 1'b0;
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = pend_r;
          end
          pend_v_nxt              = 1'b1;
          pend_nxt.vertex         = scc_pkg::FIELD_VW'(stk_rd);
          pend_nxt.component      = comp_r;
          pend_nxt.component_end  = done_pop;
          pend_nxt.run_end        = 1'b0;
          pend_nxt.edges_dropped  = dropped_r;
          if (done_pop) begin
            comp_nxt = comp_r + scc_pkg::COMP_W'(1);
          end else begin
            stk_re = 1'b1;
            stk_ra = VW'(sp_r - CW'(2));
          end
        end
      end
      scc_pkg::S_RET: begin
        depth_nxt = depth_r - CW'(1);
        if (depth_r > CW'(1)) begin
          frm_re = 1'b1;
        end else begin
          root_nxt = root_r + NW'(1);
        end
      end
      scc_pkg::S_PAR: begin
        top_u_nxt    = fr_u;
        top_cur_nxt  = fr_cur;
        top_disc_nxt = fr_disc;
        top_low_nxt  = (top_low_r < fr_low) ? top_low_r : fr_low;
      end
      scc_pkg::S_FIN: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt        = 1'b1;
            out_word_nxt         = pend_r;
            out_word_nxt.run_end = 1'b1;
          end
          pend_v_nxt     = 1'b0;
          head_v_nxt     = '0;
          edge_count_nxt = '0;
          overflow_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= scc_pkg::S_IDLE;
      vcount_r     <= scc_pkg::VCOUNT_RESET;
      edge_count_r <= '0;
      overflow_r   <= 1'b0;
      head_v_r     <= '0;
      disc_v_r     <= '0;
      onstk_r      <= '0;
      root_r       <= '0;
      visit_r      <= '0;
      sp_r         <= '0;
      depth_r      <= '0;
      comp_r       <= '0;
      dropped_r    <= 1'b0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      edge_count_r <= edge_count_nxt;
      overflow_r   <= overflow_nxt;
      head_v_r     <= head_v_nxt;
      disc_v_r     <= disc_v_nxt;
      onstk_r      <= onstk_nxt;
      root_r       <= root_nxt;
      visit_r      <= visit_nxt;
      sp_r         <= sp_nxt;
      depth_r      <= depth_nxt;
      comp_r       <= comp_nxt;
      dropped_r    <= dropped_nxt;
      pend_v_r     <= pend_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    add_s_r    <= add_s_nxt;
    add_t_r    <= add_t_nxt;
    enter_v_r  <= enter_v_nxt;
    top_u_r    <= top_u_nxt;
    top_cur_r  <= top_cur_nxt;
    top_low_r  <= top_low_nxt;
    top_disc_r <= top_disc_nxt;
    pend_r     <= pend_nxt;
    out_word_r <= out_word_nxt;
  end

  // Adjacency heads, one per vertex; head_v_r marks the ones written.
  scc_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES), .AW(VW)) u_head (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_en(head_re), .rd_addr(head_ra), .rd_data(head_rd)
  );

  // Edge store: target vertex and link to the next older edge.
  scc_ram #(.WIDTH(VW + EW), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge (
    .clk(clk), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
    .rd_en(edge_re), .rd_addr(edge_ra), .rd_data(edge_rd)
  );

  // Discovery numbers; disc_v_r marks the visited vertices.
  scc_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES), .AW(VW)) u_disc (
    .clk(clk), .wr_en(disc_we), .wr_addr(disc_wa), .wr_data(disc_wd),
    .rd_en(disc_re), .rd_addr(disc_ra), .rd_data(disc_rd)
  );

  // Component stack.
  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES), .AW(VW)) u_stack (
    .clk(clk), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
    .rd_en(stk_re), .rd_addr(stk_ra), .rd_data(stk_rd)
  );

  // Saved search frames below the top one; the low link travels with its frame.
  scc_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES), .AW(VW)) u_frame (
    .clk(clk), .wr_en(frm_we), .wr_addr(frm_wa), .wr_data(frm_wd),
    .rd_en(frm_re), .rd_addr(frm_ra), .rd_data(frm_rd)
  );

  // Every vertex with an open frame is still on the component stack. In the
  // return cycle the top frame's vertex may already have been popped.
  a_stack_covers_frames: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != scc_pkg::S_RET) |-> (sp_r >= depth_r))
    else $error("component stack shallower than frame stack");

  // A pop never starts on an empty component stack.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scc_pkg::S_POP) |-> (sp_r != '0))
    else $error("pop from empty component stack");

  // No result is left behind in the pending register once the block is idle.
  a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scc_pkg::S_IDLE) |-> !pend_v_r)
    else $error("pending result left at idle");

  // The edge store is empty right after a run completes.
  a_cleared_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scc_pkg::S_FIN && state_nxt == scc_pkg::S_IDLE)
      |=> (edge_count_r == '0 && !overflow_r))
    else $error("edge store not cleared after run");

endmodule

FILE: tb/strongly_connected_components_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strongly_connected_components_unit_tb
// Self-checking bench for the strongly connected components unit. Edge and run
// words go in through the valid/stall input channel. A scoreboard class keeps
// its own copy of the edge store and runs Tarjan's search to build the expected
// component words. Every accepted output word is checked against that list.
// Both sides idle at random. One long output hold-off fills the unit up, and
// the vertex count is changed between phases, including its extremes.
// ----------------------------------------------------------------------------
module strongly_connected_components_unit_tb;

  localparam int NV        = 64;
  localparam int NE        = 256;
  localparam int NO_LINK   = NE;
  localparam int IDLE_PCT  = 19;
  localparam int HOLD_LEN  = 400;
  localparam int SETTLE    = 300;
  localparam int WATCHDOG  = 20000;

  // Scoreboard: mirrors the edge store and predicts the words of each run.
  class scc_scoreboard;
    int        vcount;
    int        head[NV];
    int        edge_dst[NE];
    int        edge_link[NE];
    int        edge_total;
    bit        dropped_flag;
    scc_pkg::out_word_t pending_words[$];
    int        errors;
    int        words_checked;
    int        runs_seen;
    int        components_seen;

    function new();
      vcount = scc_pkg::VCOUNT_RESET;
      errors = 0;
      words_checked = 0;
      runs_seen = 0;
      components_seen = 0;
      clear_store();
    endfunction

    function void clear_store();
      foreach (head[i]) head[i] = NO_LINK;
      edge_total = 0;
      dropped_flag = 0;
    endfunction

    function void set_count(int value);
      vcount = value;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Called for every input word the unit accepts.
    function void note_input(scc_pkg::in_word_t w);
      int        n;
      int        disc[NV];
      int        low[NV];
      bit        on_stk[NV];
      int        stk[NV];
      int        sp;
      int        visits;
      int        fr_vtx[NV];
      int        fr_cur[NV];
      int        depth;
      int        comp;
      int        u;
      int        v;
      int        e;
      int        x;
      bit        done;
      scc_pkg::out_word_t r;
      scc_pkg::out_word_t run_words[$];

      n = (vcount > NV) ? NV : vcount;
      if (w.operation == scc_pkg::OP_ADD_EDGE) begin
        if (w.source_vertex >= n || w.target_vertex >= n || edge_total >= NE) begin
          dropped_flag = 1;
        end else begin
          edge_dst[edge_total] = w.target_vertex;
          edge_link[edge_total] = head[w.source_vertex];
          head[w.source_vertex] = edge_total;
          edge_total++;
        end
        return;
      end

      foreach (disc[i]) begin
        disc[i] = 0;
        on_stk[i] = 0;
      end
      sp = 0;
      visits = 0;
      depth = 0;
      comp = 0;
      runs_seen++;
      for (int root = 0; root < n; root++) begin
        if (disc[root] != 0) continue;
        // Entering a vertex numbers it, pushes it and opens a frame for it.
        visits++;
        disc[root] = visits;
        low[root] = visits;
        stk[sp++] = root;
        on_stk[root] = 1;
        fr_vtx[depth] = root;
        fr_cur[depth] = head[root];
        depth++;
        while (depth > 0) begin
          u = fr_vtx[depth-1];
          e = fr_cur[depth-1];
          if (e < NE) begin
            v = edge_dst[e];
            fr_cur[depth-1] = edge_link[e];
            // Edges stored under a larger count are skipped once it drops.
            if (v >= n) continue;
            if (disc[v] == 0) begin
              visits++;
              disc[v] = visits;
              low[v] = visits;
              stk[sp++] = v;
              on_stk[v] = 1;
              fr_vtx[depth] = v;
              fr_cur[depth] = head[v];
              depth++;
            end else if (on_stk[v] && disc[v] < low[u]) begin
              low[u] = disc[v];
            end
            continue;
          end
          if (low[u] == disc[u]) begin
            done = 0;
            while (!done && sp > 0) begin
              sp--;
              x = stk[sp];
              on_stk[x] = 0;
              done = (x == u);
              r.vertex = scc_pkg::FIELD_VW'(x);
              r.component = scc_pkg::COMP_W'(comp);
              r.component_end = done;
              r.run_end = 0;
              r.edges_dropped = dropped_flag;
              run_words.push_back(r);
            end
            comp = (comp + 1) % 64;
            components_seen++;
          end
          depth--;
          if (depth > 0 && low[u] < low[fr_vtx[depth-1]]) low[fr_vtx[depth-1]] = low[u];
        end
      end
      if (run_words.size() > 0) run_words[run_words.size()-1].run_end = 1;
      foreach (run_words[i]) pending_words.push_back(run_words[i]);
      clear_store();
    endfunction

    // Called for every output word the unit delivers.
    task check_result(scc_pkg::out_word_t got);
      scc_pkg::out_word_t exp_w;
      words_checked++;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word vertex=%0d component=%0d",
                         got.vertex, got.component));
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.vertex !== exp_w.vertex)
        report($sformatf("vertex %0d, want %0d", got.vertex, exp_w.vertex));
      if (got.component !== exp_w.component)
        report($sformatf("component %0d, want %0d", got.component, exp_w.component));
      if (got.component_end !== exp_w.component_end)
        report($sformatf("component_end %0b, want %0b", got.component_end,
                         exp_w.component_end));
      if (got.run_end !== exp_w.run_end)
        report($sformatf("run_end %0b, want %0b", got.run_end, exp_w.run_end));
      if (got.edges_dropped !== exp_w.edges_dropped)
        report($sformatf("edges_dropped %0b, want %0b", got.edges_dropped,
                         exp_w.edges_dropped));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  scc_pkg::in_word_t            in_word;
  logic                         out_valid;
  logic                         out_stall;
  scc_pkg::out_word_t           out_word;
  logic                         cfg_wr_en;
  logic [scc_pkg::VCOUNT_W-1:0] cfg_wr_data;

  scc_scoreboard sb;
  bit            calm;       // when set, neither side idles
  bit            hold_req;   // asks the receiver for one long hold-off
  int            words_sent;
  int            quiet_cycles;

  strongly_connected_components_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Inputs only change at rising edges, so the falling edge is a safe point
  // to see which handshakes will complete at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus the long hold-off on request, which is
  // counted here so the sender keeps offering words meanwhile.
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offers one word and returns at the edge that accepts it. An idle gap is
  // taken first when one is drawn, so valid gets one assignment per edge.
  task send_word(logic op, int src, int dst);
    scc_pkg::in_word_t w;
    bit       taken;
    w.operation = op;
    w.source_vertex = scc_pkg::FIELD_VW'(src);
    w.target_vertex = scc_pkg::FIELD_VW'(dst);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_input(w);
    words_sent++;
  endtask

  task add_edge(int src, int dst);
    send_word(scc_pkg::OP_ADD_EDGE, src, dst);
  endtask

  task run_search();
    send_word(scc_pkg::OP_RUN, $urandom_range(63), $urandom_range(63));
  endtask

  // Waits until every expected word has come, then lets the unit settle.
  // An add produces no word, so the settle time covers any edge still in work.
  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_count(int value);
    cfg_wr_en <= 1;
    cfg_wr_data <= scc_pkg::VCOUNT_W'(value);
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.set_count(value & 7'h7f);
  endtask

  // One random graph: mostly in-range edges, a few fully random ones, at times a lowered count, then a run.
  task random_graph(int n, int m, bit lower);
    int lim;
    drain();
    write_count(n);
    lim = (n > NV) ? NV : n;
    for (int i = 0; i < m; i++) begin
      if (lim == 0 || $urandom_range(99) < 8)
        add_edge($urandom_range(63), $urandom_range(63));
      else
        add_edge($urandom_range(lim-1), $urandom_range(lim-1));
    end
    if (lower && lim > 1) begin
      drain();
      write_count($urandom_range(lim-1, 1));
    end
    run_search();
  endtask

  initial begin
    int n;
    int m;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_word = '0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    calm = 0;
    hold_req = 0;
    words_sent = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: corner vertices and self loops at the reset count.
    add_edge(63, 0);
    add_edge(0, 63);
    add_edge(63, 63);
    add_edge(0, 0);
    run_search();
    // A count above the maximum acts as the maximum.
    drain();
    write_count(127);
    add_edge(63, 62);
    add_edge(62, 63);
    run_search();
    // Out-of-range edges are dropped and raise the flag for the next run.
    drain();
    write_count(3);
    add_edge(5, 1);
    add_edge(1, 7);
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 0);
    run_search();
    run_search();
    // With no vertices every edge drops and a run yields nothing.
    drain();
    write_count(0);
    add_edge(0, 0);
    run_search();
    // Lowering the count after adding hides edges and vertices above it.
    drain();
    write_count(5);
    add_edge(4, 0);
    add_edge(0, 4);
    add_edge(3, 1);
    add_edge(1, 0);
    drain();
    write_count(2);
    run_search();
    drain();
    write_count(1);
    run_search();

    // Filling the edge store past capacity drops the surplus.
    drain();
    write_count(4);
    for (int i = 0; i < NE + 4; i++) add_edge($urandom_range(3), $urandom_range(3));
    run_search();

    // Long output hold-off while edges keep coming, so the input stalls.
    random_graph(16, 30, 0);
    hold_req = 1;
    for (int i = 0; i < 12; i++) add_edge($urandom_range(15), $urandom_range(15));
    run_search();

    // A stretch without any idling on either side.
    calm = 1;
    random_graph(64, 24, 0);
    random_graph(8, 10, 0);
    calm = 0;

    while (words_sent < 395) begin
      case ($urandom_range(9))
        0:       n = 64 + $urandom_range(63);
        1:       n = $urandom_range(64, 33);
        default: n = $urandom_range(12, 1);
      endcase
      m = $urandom_range(2 * ((n > NV) ? NV : n) + 1, 0);
      if (m > 30) m = 30;
      random_graph(n, m, $urandom_range(7) == 0);
    end

    drain();
    $display("Covered %0d words, %0d runs, %0d components, %0d output words checked.",
             words_sent, sb.runs_seen, sb.components_seen, sb.words_checked);
    $display("Vertex counts from 0 to 127, dropped edges, a full store and a long hold-off.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
